@@ rtl/iir_df2t_pkg.sv @@
package iir_df2t_pkg;

    // filter order, 1 to 3
    localparam int ORDER = 3;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int DELAY_W  = 48;
    localparam int FRAC_W   = 20;

    // sum of a delay element and a product, and that sum less a product
    localparam int SUM_W  = DELAY_W + 1;
    localparam int DIFF_W = DELAY_W + 2;

    localparam int NUM_REGS = 7;
    localparam int INDEX_W  = 3;
    localparam int CNT_W    = $clog2(ORDER + 1);
    localparam int DLY_IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [DELAY_W-1:0]  delay_t;
    typedef logic [INDEX_W-1:0]         reg_idx_t;

    // register indexes
    localparam reg_idx_t REG_B0     = 3'd0;
    localparam reg_idx_t REG_A_BASE = 3'd3;  // a[i] sits at REG_A_BASE + i
    localparam reg_idx_t REG_LAST   = 3'd6;

    localparam coef_t COEF_ONE = 24'sd1048576;
    localparam coef_t COEF_RESET [NUM_REGS] = '{COEF_ONE, '0, '0, '0, '0, '0, '0};

    localparam sample_t SAMPLE_MAX = 24'sh7fffff;
    localparam sample_t SAMPLE_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_B0,
        S_OUT,
        S_MUL_B,
        S_ACC,
        S_UPD
    } state_t;

    function automatic delay_t sat48(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'({1'b0, {(DELAY_W-1){1'b1}}});
        lo = -hi - DIFF_W'(1);
        if (v > hi)
            return delay_t'(hi);
        else if (v < lo)
            return delay_t'(lo);
        else
            return delay_t'(v);
    endfunction

endpackage

@@ rtl/iir_df2t_if.sv @@
interface iir_df2t_in_if;
    logic                     valid;
    logic                     ready;
    iir_df2t_pkg::sample_t    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df2t_out_if;
    logic                     valid;
    logic                     ready;
    iir_df2t_pkg::sample_t    sample_out;
    logic                     clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iir_df2t_cfg_if;
    logic                     valid;
    logic                     ready;
    iir_df2t_pkg::reg_idx_t   index;
    iir_df2t_pkg::coef_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/iir_df2t_mul.sv @@
module iir_df2t_mul (
    input  logic                  clk,
    input  iir_df2t_pkg::coef_t   op_coef,
    input  iir_df2t_pkg::sample_t op_sample,
    output iir_df2t_pkg::prod_t   prod
);

    iir_df2t_pkg::prod_t prod_reg;
    iir_df2t_pkg::prod_t prod_next;

    // full-width signed product, never overflows 48 bits
    assign prod_next = iir_df2t_pkg::prod_t'(op_coef) * iir_df2t_pkg::prod_t'(op_sample);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/iir_filter_df2_transposed_unit.sv @@
// Third-order IIR filter in transposed direct form II for 24-bit signed samples with
// Q4.20 coefficients (a0 fixed at 1). One registered 24x24 multiplier is shared by all
// taps: a sample goes through the b0 multiply and the output step, then per tap a
// multiply issue, accumulate and delay update, and the unit returns to idle. The result
// word is formed in the output step and sits in an output register, so it may wait while
// the delay update finishes; audio.ready is high only while idle and no coefficient
// write is pending. Coefficient writes on coef are taken while idle, have priority over
// a sample, and any write to a valid index clears the delay line; indexes beyond the
// last register are ignored.
module iir_filter_df2_transposed_unit (
    input  logic           clk,
    input  logic           rst_n,
    iir_df2t_in_if.sink    audio,
    iir_df2t_out_if.source filtered,
    iir_df2t_cfg_if.sink   coef
);

    iir_df2t_pkg::state_t  state_reg;
    iir_df2t_pkg::state_t  state_next;
    logic [iir_df2t_pkg::CNT_W-1:0] tap_reg;
    logic [iir_df2t_pkg::CNT_W-1:0] tap_next;
    logic [iir_df2t_pkg::CNT_W-1:0] tap_m1;

    iir_df2t_pkg::coef_t   coef_reg [iir_df2t_pkg::NUM_REGS];
    iir_df2t_pkg::coef_t   coef_next [iir_df2t_pkg::NUM_REGS];
    iir_df2t_pkg::delay_t  d_reg [iir_df2t_pkg::ORDER];
    iir_df2t_pkg::delay_t  d_next [iir_df2t_pkg::ORDER];

    iir_df2t_pkg::sample_t x_reg;
    iir_df2t_pkg::sample_t x_next;
    iir_df2t_pkg::sample_t y_reg;
    iir_df2t_pkg::sample_t y_next;
    logic signed [iir_df2t_pkg::SUM_W-1:0] sum_reg;
    logic signed [iir_df2t_pkg::SUM_W-1:0] sum_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    iir_df2t_pkg::sample_t out_sample_reg;
    iir_df2t_pkg::sample_t out_sample_next;
    logic                  out_clip_reg;
    logic                  out_clip_next;

    iir_df2t_pkg::coef_t   mul_coef;
    iir_df2t_pkg::sample_t mul_sample;
    iir_df2t_pkg::prod_t   prod;

    logic signed [iir_df2t_pkg::SUM_W:0]           round_acc;
    logic signed [iir_df2t_pkg::SUM_W-iir_df2t_pkg::FRAC_W:0] y_full;
    iir_df2t_pkg::sample_t y_sat;
    logic                  y_clip;
    iir_df2t_pkg::delay_t  d_tap;

    iir_df2t_mul u_mul (
        .clk       (clk),
        .op_coef   (mul_coef),
        .op_sample (mul_sample),
        .prod      (prod)
    );

    // round half up at the binary point, then clamp to 24 bits
    always_comb
    begin
        round_acc = (iir_df2t_pkg::SUM_W+1)'(d_reg[0])
                  + (iir_df2t_pkg::SUM_W+1)'(prod)
                  + (iir_df2t_pkg::SUM_W+1)'(1 << (iir_df2t_pkg::FRAC_W - 1));
        y_full = round_acc[iir_df2t_pkg::SUM_W:iir_df2t_pkg::FRAC_W];
        y_clip = 1'b0;
        if (y_full > $bits(y_full)'(iir_df2t_pkg::SAMPLE_MAX))
        begin
            y_sat  = iir_df2t_pkg::SAMPLE_MAX;
            y_clip = 1'b1;
        end
        else if (y_full < $bits(y_full)'(iir_df2t_pkg::SAMPLE_MIN))
        begin
            y_sat  = iir_df2t_pkg::SAMPLE_MIN;
            y_clip = 1'b1;
        end
        else
        begin
            y_sat = iir_df2t_pkg::sample_t'(y_full);
        end
    end

    assign tap_m1 = tap_reg - 1'b1;
    // the last delay element has no successor
    assign d_tap = (tap_reg < iir_df2t_pkg::CNT_W'(iir_df2t_pkg::ORDER)) ?
                   d_reg[tap_reg[iir_df2t_pkg::DLY_IDX_W-1:0]] : '0;

    always_comb
    begin
        state_next      = state_reg;
        tap_next        = tap_reg;
        coef_next       = coef_reg;
        d_next          = d_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && !filtered.ready;
        out_sample_next = out_sample_reg;
        out_clip_next   = out_clip_reg;
        mul_coef        = coef_reg[iir_df2t_pkg::REG_B0];
        mul_sample      = x_reg;

        case (state_reg)
            iir_df2t_pkg::S_IDLE:
            begin
                if (coef.valid)
                begin
                    if (coef.index <= iir_df2t_pkg::REG_LAST)
                    begin
                        coef_next[coef.index] = coef.data;
                        d_next = '{default: '0};
                    end
                end
                else if (audio.valid)
                begin
                    x_next     = audio.sample_in;
                    state_next = iir_df2t_pkg::S_MUL_B0;
                end
            end
            iir_df2t_pkg::S_MUL_B0:
            begin
                mul_coef   = coef_reg[iir_df2t_pkg::REG_B0];
                mul_sample = x_reg;
                state_next = iir_df2t_pkg::S_OUT;
            end
            iir_df2t_pkg::S_OUT:
            begin
                // wait here while the previous word has not been taken
                if (!out_valid_reg || filtered.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y_sat;
                    out_clip_next   = y_clip;
                    y_next          = y_sat;
                    tap_next        = iir_df2t_pkg::CNT_W'(1);
                    state_next      = iir_df2t_pkg::S_MUL_B;
                end
            end
            iir_df2t_pkg::S_MUL_B:
            begin
                mul_coef   = coef_reg[iir_df2t_pkg::INDEX_W'(tap_reg)];
                mul_sample = x_reg;
                state_next = iir_df2t_pkg::S_ACC;
            end
            iir_df2t_pkg::S_ACC:
            begin
                sum_next   = iir_df2t_pkg::SUM_W'(d_tap) + iir_df2t_pkg::SUM_W'(prod);
                mul_coef   = coef_reg[iir_df2t_pkg::REG_A_BASE
                                      + iir_df2t_pkg::INDEX_W'(tap_reg)];
                mul_sample = y_reg;
                state_next = iir_df2t_pkg::S_UPD;
            end
            iir_df2t_pkg::S_UPD:
            begin
                d_next[tap_m1[iir_df2t_pkg::DLY_IDX_W-1:0]] = iir_df2t_pkg::sat48(
                    iir_df2t_pkg::DIFF_W'(sum_reg) - iir_df2t_pkg::DIFF_W'(prod));
                if (tap_reg == iir_df2t_pkg::CNT_W'(iir_df2t_pkg::ORDER))
                begin
                    state_next = iir_df2t_pkg::S_IDLE;
                end
                else
                begin
                    tap_next   = tap_reg + 1'b1;
                    state_next = iir_df2t_pkg::S_MUL_B;
                end
            end
            default:
            begin
                state_next = iir_df2t_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iir_df2t_pkg::S_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
            coef_reg      <= iir_df2t_pkg::COEF_RESET;
            d_reg         <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
            coef_reg      <= coef_next;
            d_reg         <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        sum_reg        <= sum_next;
        out_sample_reg <= out_sample_next;
        out_clip_reg   <= out_clip_next;
    end

    assign audio.ready         = (state_reg == iir_df2t_pkg::S_IDLE) && !coef.valid;
    assign coef.ready          = (state_reg == iir_df2t_pkg::S_IDLE);
    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = out_sample_reg;
    assign filtered.clipped    = out_clip_reg;

endmodule

@@ rtl/iir_df2t_checker.sv @@
module iir_df2t_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input iir_df2t_pkg::sample_t out_sample,
    input logic                  out_clipped,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // a sample keeps the unit busy through at least the multiply and round states
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input taken again while a sample is in work");

    // a coefficient write and a sample never land on the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && cfg_valid && cfg_ready))
        else $error("coefficient write and sample accepted together");

    // a clipped word carries one of the two limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_clipped) |->
            (out_sample == iir_df2t_pkg::SAMPLE_MAX) ||
            (out_sample == iir_df2t_pkg::SAMPLE_MIN))
        else $error("clip flag with an unsaturated sample");

    // a word appears only while the delay update still runs
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result word appeared while idle");

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(out_sample) && $stable(out_clipped))
        else $error("stalled result word changed");

endmodule

bind iir_filter_df2_transposed_unit iir_df2t_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (audio.valid),
    .in_ready    (audio.ready),
    .out_valid   (filtered.valid),
    .out_ready   (filtered.ready),
    .out_sample  (filtered.sample_out),
    .out_clipped (filtered.clipped),
    .cfg_valid   (coef.valid),
    .cfg_ready   (coef.ready)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import iir_df2t_pkg::*;

    localparam int N_PHASE      = 12;
    localparam int PHASE_WORDS  = 155;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 3 + 3 * ORDER + 8;
    localparam int MAX_REPORTS  = 10;

    localparam reg_idx_t R_B1  = REG_B0 + 3'd1;
    localparam reg_idx_t R_B2  = REG_B0 + 3'd2;
    localparam reg_idx_t R_B3  = REG_B0 + 3'd3;
    localparam reg_idx_t R_A1  = REG_A_BASE + 3'd1;
    localparam reg_idx_t R_A2  = REG_A_BASE + 3'd2;
    localparam reg_idx_t R_A3  = REG_A_BASE + 3'd3;
    localparam reg_idx_t R_BAD = REG_LAST + 3'd1;

    localparam coef_t COEF_MAX = 24'sh7fffff;
    localparam coef_t COEF_MIN = 24'sh800000;

    localparam logic ROW_S = 1'b0;  // sample word
    localparam logic ROW_C = 1'b1;  // coefficient write

    typedef struct packed {
        logic                      kind;
        reg_idx_t                  idx;
        logic signed [SAMPLE_W-1:0] val;
        logic                      known;
        sample_t                   y;
        logic                      clip;
    } dir_row_t;

    typedef struct packed {
        sample_t y;
        logic    clip;
    } filt_word_t;

    localparam int N_DIR = 33;
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{ROW_S, REG_B0, 24'sd0,       1'b1, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MAX, 1'b0},
        '{ROW_S, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MIN, 1'b0},
        '{ROW_S, REG_B0, 24'sd1,       1'b1, 24'sd1,     1'b0},
        '{ROW_S, REG_B0, -24'sd1,      1'b1, -24'sd1,    1'b0},
        '{ROW_C, REG_B0, COEF_MAX,     1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MAX, 1'b1},
        '{ROW_S, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MIN, 1'b1},
        '{ROW_C, REG_B0, COEF_MIN,     1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MAX, 1'b1},
        '{ROW_S, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MIN, 1'b1},
        '{ROW_C, REG_B0, COEF_ONE,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B1,   24'sd524288,  1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A1,   24'sd786432,  1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B2,   -24'sd262144, 1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A2,   24'sd131072,  1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B3,   24'sd65536,   1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A3,   -24'sd65536,  1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, 24'sd1000,    1'b1, 24'sd1000,  1'b0},
        '{ROW_S, REG_B0, -24'sd4000,   1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, 24'sd777,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_BAD,  24'sh5a5a5a,  1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, 24'sd0,       1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B1,   COEF_MAX,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B2,   COEF_MAX,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_B3,   COEF_MAX,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A1,   COEF_MIN,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A2,   COEF_MIN,     1'b0, 24'sd0,     1'b0},
        '{ROW_C, R_A3,   COEF_MIN,     1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MAX,   1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MAX,   1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, SAMPLE_MIN,   1'b0, 24'sd0,     1'b0},
        '{ROW_S, REG_B0, 24'sd0,       1'b0, 24'sd0,     1'b0}
    };

    logic clk;
    logic rst_n;

    iir_df2t_in_if  audio_if ();
    iir_df2t_out_if filt_if ();
    iir_df2t_cfg_if coef_if ();

    iir_filter_df2_transposed_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .audio    (audio_if),
        .filtered (filt_if),
        .coef     (coef_if)
    );

    // filter state as the block should hold it
    delay_t dly_st [ORDER];
    coef_t  b_coef [0:ORDER];
    coef_t  a_coef [0:ORDER];  // a_coef[0] is the implied 1.0, never used

    filt_word_t pending_words [$];

    int   errors;
    int   words_seen;
    int   in_idle_pct;
    int   out_idle_pct;
    bit   no_idle;
    bit   hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic delay_t saturate_delay(input longint v);
        longint hi;
        hi = (longint'(1) <<< (DELAY_W - 1)) - 1;
        if (v > hi)
            return delay_t'(hi);
        else if (v < -hi - 1)
            return delay_t'(-hi - 1);
        else
            return delay_t'(v);
    endfunction

    task automatic filter_step(input sample_t x, output filt_word_t w);
        longint acc;
        longint yl;
        longint nxt;
        int     i;
        acc = longint'(dly_st[0]) + longint'(b_coef[0]) * longint'(x);
        // round half up, then back to sample scale
        yl = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        w.clip = 1'b0;
        if (yl > longint'(SAMPLE_MAX))
        begin
            yl = longint'(SAMPLE_MAX);
            w.clip = 1'b1;
        end
        else if (yl < longint'(SAMPLE_MIN))
        begin
            yl = longint'(SAMPLE_MIN);
            w.clip = 1'b1;
        end
        w.y = sample_t'(yl);
        // feedback uses the saturated output
        for (i = 0; i < ORDER - 1; i++)
        begin
            nxt = longint'(dly_st[i + 1]) + longint'(b_coef[i + 1]) * longint'(x)
                  - longint'(a_coef[i + 1]) * yl;
            dly_st[i] = saturate_delay(nxt);
        end
        nxt = longint'(b_coef[ORDER]) * longint'(x) - longint'(a_coef[ORDER]) * yl;
        dly_st[ORDER - 1] = saturate_delay(nxt);
    endtask

    task automatic apply_coef(input reg_idx_t idx, input coef_t v);
        int i;
        if (idx <= REG_LAST)
        begin
            if (idx <= REG_A_BASE)
                b_coef[idx] = v;
            else
                a_coef[idx - REG_A_BASE] = v;
            for (i = 0; i < ORDER; i++)
                dly_st[i] = '0;
        end
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return sample_t'($urandom) >>> $urandom_range(0, SAMPLE_W - 1);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(0, 9))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            3:       return coef_t'($urandom);
            // mostly small taps so the filter stays in range for a while
            default: return coef_t'($urandom) >>> $urandom_range(3, 12);
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 25;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(input sample_t x, input logic known, input filt_word_t typed);
        filt_word_t w;
        if (!no_idle && $urandom_range(0, 99) < in_idle_pct)
        begin
            audio_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        audio_if.valid     <= 1'b1;
        audio_if.sample_in <= x;
        do
            @(posedge clk);
        while (!audio_if.ready);
        filter_step(x, w);
        pending_words.push_back(known ? typed : w);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        audio_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_coef(input reg_idx_t idx, input coef_t v);
        coef_if.valid <= 1'b1;
        coef_if.index <= idx;
        coef_if.data  <= v;
        do
            @(posedge clk);
        while (!coef_if.ready);
        apply_coef(idx, v);
        @(negedge clk);
        coef_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // output side: random stalls plus one long hold-off on request
    initial
    begin
        filt_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                filt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                filt_if.ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 99) < out_idle_pct)
            begin
                filt_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                filt_if.ready <= 1'b1;
            end
            else
                filt_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        filt_word_t exp_w;
        if (rst_n && filt_if.valid && filt_if.ready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("tb: unexpected output word %0d: sample_out %0d clipped %0b",
                             words_seen, filt_if.sample_out, filt_if.clipped);
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (filt_if.sample_out !== exp_w.y || filt_if.clipped !== exp_w.clip)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("tb: word %0d: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                                 words_seen, exp_w.y, filt_if.sample_out,
                                 exp_w.clip, filt_if.clipped);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((audio_if.valid && audio_if.ready) || (filt_if.valid && filt_if.ready)
                || (coef_if.valid && coef_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int         r;
        int         p;
        int         k;
        coef_t      v;
        filt_word_t typed;

        errors       = 0;
        words_seen   = 0;
        in_idle_pct  = 10;
        out_idle_pct = 10;
        no_idle      = 1'b0;
        hold_req     = 1'b0;

        rst_n              = 1'b0;
        audio_if.valid     <= 1'b0;
        audio_if.sample_in <= '0;
        coef_if.valid      <= 1'b0;
        coef_if.index      <= REG_B0;
        coef_if.data       <= '0;

        for (r = 0; r <= ORDER; r++)
        begin
            b_coef[r] = COEF_RESET[r];
            a_coef[r] = (r == 0) ? coef_t'(0) : COEF_RESET[REG_A_BASE + r];
        end
        for (r = 0; r < ORDER; r++)
            dly_st[r] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < N_DIR; r++)
        begin
            if (DIR_TAB[r].kind == ROW_C)
            begin
                wait_idle();
                write_coef(DIR_TAB[r].idx, coef_t'(DIR_TAB[r].val));
            end
            else
            begin
                typed.y    = DIR_TAB[r].y;
                typed.clip = DIR_TAB[r].clip;
                send_sample(sample_t'(DIR_TAB[r].val), DIR_TAB[r].known, typed);
            end
        end

        typed = '0;
        for (p = 0; p < N_PHASE; p++)
        begin
            wait_idle();
            for (r = 0; r <= REG_LAST; r++)
            begin
                if (p == 0)
                    v = COEF_MAX;
                else if (p == 1)
                    v = COEF_MIN;
                else if (p == 2)
                    v = COEF_RESET[r];
                else
                    v = pick_coef();
                write_coef(reg_idx_t'(r), v);
            end
            if ($urandom_range(0, 1) == 0)
                write_coef(R_BAD, coef_t'($urandom));

            in_idle_pct  = pick_idle_pct();
            out_idle_pct = pick_idle_pct();
            if (p == N_PHASE - 1)
                no_idle = 1'b1;

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // long receiver hold-off so the block backs up into its input
                if (p == 3 && k == 20)
                    hold_req = 1'b1;
                // sender pause until the output side has caught up
                if (p == 6 && k == 70)
                    wait_idle();
                send_sample(pick_sample(), 1'b0, typed);
            end
        end

        audio_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
        begin
            errors += pending_words.size();
            $display("tb: %0d output words never arrived", pending_words.size());
        end
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/iir_df2t_pkg.sv
rtl/iir_df2t_if.sv
rtl/iir_df2t_mul.sv
rtl/iir_filter_df2_transposed_unit.sv
rtl/iir_df2t_checker.sv
test/tb.sv
